// ===== design/sorted_priority_queue_update_key_defines.svh =====
// assertion macros for the sorted priority queue block
// expects aclk and aresetn in the scope of each use
`ifndef SORTED_PRIORITY_QUEUE_UPDATE_KEY_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UPDATE_KEY_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/spq_pkg.sv =====
// shared types and constants for the sorted priority queue block
// no dependencies
package spq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OCC_W = 5;

    // id in the low bits, matching the input tdata layout
    typedef struct packed {
        logic [15:0] arr;
        logic [7:0]  sev;
        logic [7:0]  id;
    } spq_entry_t;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_UPDATE = 2'd2
    } spq_op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } spq_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_REMOVE,
        ST_REM_RD,
        ST_REM_WR,
        ST_PLACE,
        ST_INS_RD,
        ST_INS_CHK,
        ST_INS_LAST,
        ST_DONE
    } spq_state_t;

    typedef struct packed {
        logic outranks;
        logic id_match;
    } spq_cmp_t;

endpackage

// ===== design/spq_store.sv =====
// entry store: one write port, one registered read port
// depends on spq_pkg
module spq_store (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [spq_pkg::IDX_W-1:0] wr_addr,
    input  spq_pkg::spq_entry_t       wr_data,
    input  logic [spq_pkg::IDX_W-1:0] rd_addr,
    output spq_pkg::spq_entry_t       rd_data
);

    spq_pkg::spq_entry_t mem [spq_pkg::DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== design/spq_cmp.sv =====
// shared compare unit: priority order and id match against one stored entry
// depends on spq_pkg
module spq_cmp (
    input  spq_pkg::spq_entry_t key,
    input  spq_pkg::spq_entry_t entry,
    output spq_pkg::spq_cmp_t   result
);

    always_comb begin
        result.outranks = (key.sev > entry.sev)
                       || ((key.sev == entry.sev) && (key.arr < entry.arr));
        result.id_match = (key.id == entry.id);
    end

endmodule

// ===== design/sorted_priority_queue_update_key.sv =====
// sorted priority queue: one operation per transaction, one result per operation
// insert walks from the tail toward the front, moving each outranked entry down one place;
// pop takes the front entry and pulls the later entries up one place; update scans for
// the first id match, then does the removal and the insert
// throughput: one operation at a time, next input taken the cycle after the result is loaded
// reset: synchronous active-low aresetn empties the queue and drops any pending result
module sorted_priority_queue_update_key (
    input  logic        aclk,
    input  logic        aresetn,
    // input transaction
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // entry_id[7:0], severity[15:8], arrival_time[31:16]
    input  logic [1:0]  s_axis_tuser,  // operation[1:0]
    // result transaction
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // popped_id[7:0], popped_severity[15:8],
                                       // popped_arrival[31:16], occupancy[36:32], zero[39:37]
    output logic [1:0]  m_axis_tuser   // status[1:0]
);

    `include "sorted_priority_queue_update_key_defines.svh"

    localparam int IDX_W = spq_pkg::IDX_W;
    localparam int CNT_W = spq_pkg::CNT_W;
    localparam int OCC_W = spq_pkg::OCC_W;

    spq_pkg::spq_state_t state_reg, state_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    // operation being worked on; key holds id, severity and the arrival used for placing
    logic [1:0]            op_reg, op_next;
    spq_pkg::spq_entry_t   key_reg, key_next;
    spq_pkg::spq_status_t  status_reg, status_next;
    spq_pkg::spq_entry_t   pop_reg, pop_next;

    // registered result, parts the output side from the sequencer
    logic                  m_valid_reg;
    spq_pkg::spq_status_t  m_status_reg;
    spq_pkg::spq_entry_t   m_pop_reg;
    logic [OCC_W-1:0]      m_occ_reg;

    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    spq_pkg::spq_entry_t   mem_wdata;
    logic [IDX_W-1:0]      mem_raddr;
    spq_pkg::spq_entry_t   mem_rdata;

    spq_pkg::spq_cmp_t     cmp;

    logic                  s_accept;
    logic                  out_load;

    // pending result reports a full or an empty queue
    logic                  res_full;
    logic                  res_empty;

    spq_store u_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // one comparator serves both the id scan and the ordered insert walk
    spq_cmp u_cmp (
        .key    (key_reg),
        .entry  (mem_rdata),
        .result (cmp)
    );

    assign s_axis_tready = (state_reg == spq_pkg::ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == spq_pkg::ST_DONE) && (!m_valid_reg || m_axis_tready);

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = {3'b000, m_occ_reg, m_pop_reg};

    assign res_full  = m_valid_reg && (m_status_reg == spq_pkg::STAT_FULL);
    assign res_empty = m_valid_reg && (m_status_reg == spq_pkg::STAT_EMPTY);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= spq_pkg::ST_IDLE;
            idx_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        pop_reg    <= pop_next;
        if (out_load) begin
            m_status_reg <= status_reg;
            m_pop_reg    <= pop_reg;
            m_occ_reg    <= OCC_W'(count_reg);
        end
    end

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        status_next = status_reg;
        pop_next    = pop_reg;
        mem_we      = 1'b0;
        mem_waddr   = idx_reg[IDX_W-1:0];
        mem_wdata   = key_reg;
        mem_raddr   = idx_reg[IDX_W-1:0];

        case (state_reg)
            spq_pkg::ST_IDLE: begin
                if (s_accept) begin
                    op_next    = s_axis_tuser;
                    key_next   = s_axis_tdata;
                    state_next = spq_pkg::ST_DISPATCH;
                end
            end

            spq_pkg::ST_DISPATCH: begin
                status_next = spq_pkg::STAT_OK;
                pop_next    = '0;
                idx_next    = '0;
                case (op_reg)
                    spq_pkg::OP_INSERT: begin
                        if (count_reg == CNT_W'(spq_pkg::DEPTH)) begin
                            status_next = spq_pkg::STAT_FULL;
                            state_next  = spq_pkg::ST_DONE;
                        end else begin
                            state_next = spq_pkg::ST_PLACE;
                        end
                    end
                    spq_pkg::OP_POP: begin
                        if (count_reg == '0) begin
                            status_next = spq_pkg::STAT_EMPTY;
                            state_next  = spq_pkg::ST_DONE;
                        end else begin
                            state_next = spq_pkg::ST_SCAN_RD;
                        end
                    end
                    spq_pkg::OP_UPDATE: begin
                        if (count_reg == '0) begin
                            status_next = spq_pkg::STAT_NOT_FOUND;
                            state_next  = spq_pkg::ST_DONE;
                        end else begin
                            state_next = spq_pkg::ST_SCAN_RD;
                        end
                    end
                    default: begin
                        // unused code: nothing changes
                        state_next = spq_pkg::ST_DONE;
                    end
                endcase
            end

            spq_pkg::ST_SCAN_RD: begin
                state_next = spq_pkg::ST_SCAN_CHK;
            end

            // pop takes the front entry; update walks until the first id match or the end of the queue
            spq_pkg::ST_SCAN_CHK: begin
                if (op_reg == spq_pkg::OP_POP) begin
                    pop_next   = mem_rdata;
                    state_next = spq_pkg::ST_REMOVE;
                end else if (cmp.id_match) begin
                    key_next.arr = mem_rdata.arr;
                    state_next   = spq_pkg::ST_REMOVE;
                end else if (CNT_W'(idx_reg + 1'b1) == count_reg) begin
                    status_next = spq_pkg::STAT_NOT_FOUND;
                    state_next  = spq_pkg::ST_DONE;
                end else begin
                    idx_next   = CNT_W'(idx_reg + 1'b1);
                    state_next = spq_pkg::ST_SCAN_RD;
                end
            end

            // close the gap at idx by pulling later entries up one place
            spq_pkg::ST_REMOVE: begin
                if (CNT_W'(idx_reg + 1'b1) == count_reg) begin
                    count_next = CNT_W'(count_reg - 1'b1);
                    state_next = (op_reg == spq_pkg::OP_POP) ? spq_pkg::ST_DONE
                                                             : spq_pkg::ST_PLACE;
                end else begin
                    state_next = spq_pkg::ST_REM_RD;
                end
            end

            spq_pkg::ST_REM_RD: begin
                mem_raddr  = IDX_W'(idx_reg + 1'b1);
                state_next = spq_pkg::ST_REM_WR;
            end

            spq_pkg::ST_REM_WR: begin
                mem_we     = 1'b1;
                mem_wdata  = mem_rdata;
                idx_next   = CNT_W'(idx_reg + 1'b1);
                state_next = spq_pkg::ST_REMOVE;
            end

            // insert walks from the tail toward the front, moving outranked entries down
            spq_pkg::ST_PLACE: begin
                idx_next   = count_reg;
                state_next = (count_reg == '0) ? spq_pkg::ST_INS_LAST : spq_pkg::ST_INS_RD;
            end

            spq_pkg::ST_INS_RD: begin
                mem_raddr  = IDX_W'(idx_reg - 1'b1);
                state_next = spq_pkg::ST_INS_CHK;
            end

            spq_pkg::ST_INS_CHK: begin
                mem_we = 1'b1;
                if (cmp.outranks) begin
                    mem_wdata  = mem_rdata;
                    idx_next   = CNT_W'(idx_reg - 1'b1);
                    state_next = (idx_reg == CNT_W'(1)) ? spq_pkg::ST_INS_LAST
                                                        : spq_pkg::ST_INS_RD;
                end else begin
                    // full ties stay behind existing entries
                    count_next = CNT_W'(count_reg + 1'b1);
                    state_next = spq_pkg::ST_DONE;
                end
            end

            spq_pkg::ST_INS_LAST: begin
                mem_we     = 1'b1;
                count_next = CNT_W'(count_reg + 1'b1);
                state_next = spq_pkg::ST_DONE;
            end

            spq_pkg::ST_DONE: begin
                if (out_load) begin
                    state_next = spq_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = spq_pkg::ST_IDLE;
            end
        endcase
    end

    // checks on the sequencer and the reported result
    `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(spq_pkg::DEPTH), "count over depth")
    `SPQ_ASSERT_NEXT(a_accept_dispatch, s_accept, state_reg == spq_pkg::ST_DISPATCH, "no dispatch")
    `SPQ_ASSERT_NOW(a_full_occ, res_full, m_occ_reg == OCC_W'(spq_pkg::DEPTH), "full not at depth")
    `SPQ_ASSERT_NOW(a_empty_occ, res_empty, m_occ_reg == '0, "empty but entries held")

endmodule

// ===== sim/sorted_priority_queue_update_key_tb.sv =====
// self-checking testbench for the sorted priority queue block
// depends on spq_pkg and sorted_priority_queue_update_key from the design folder
// keeps its own ordered copy of the queue and checks every result transaction against it

typedef struct packed {
    spq_pkg::spq_status_t status;
    logic [7:0]           popped_id;
    logic [7:0]           popped_sev;
    logic [15:0]          popped_arr;
    logic [4:0]           occupancy;
} queue_response_t;

class priority_queue_tracker;
    spq_pkg::spq_entry_t held_entries[$];
    queue_response_t     pending_responses[$];
    int unsigned         mismatch_count;
    int unsigned         response_index;

    function bit outranks(logic [7:0] sev, logic [15:0] arr, spq_pkg::spq_entry_t other);
        return (sev > other.sev) || (sev == other.sev && arr < other.arr);
    endfunction

    // full ties land behind the entries already held
    function void place_entry(logic [7:0] id, logic [7:0] sev, logic [15:0] arr);
        spq_pkg::spq_entry_t fresh;
        int                  pos;
        fresh.id  = id;
        fresh.sev = sev;
        fresh.arr = arr;
        pos = 0;
        while (pos < held_entries.size() && !outranks(sev, arr, held_entries[pos]))
            pos++;
        held_entries.insert(pos, fresh);
    endfunction

    // called once per accepted input transaction
    function void apply_operation(logic [1:0] op, logic [7:0] id, logic [7:0] sev,
                                  logic [15:0] arr);
        queue_response_t want;
        int              hit;
        logic [15:0]     kept_arr;
        want = '0;
        want.status = spq_pkg::STAT_OK;
        case (op)
            spq_pkg::OP_INSERT: begin
                if (held_entries.size() >= spq_pkg::DEPTH)
                    want.status = spq_pkg::STAT_FULL;
                else
                    place_entry(id, sev, arr);
            end
            spq_pkg::OP_POP: begin
                if (held_entries.size() == 0) begin
                    want.status = spq_pkg::STAT_EMPTY;
                end else begin
                    want.popped_id  = held_entries[0].id;
                    want.popped_sev = held_entries[0].sev;
                    want.popped_arr = held_entries[0].arr;
                    void'(held_entries.pop_front());
                end
            end
            spq_pkg::OP_UPDATE: begin
                hit = -1;
                for (int i = 0; i < held_entries.size(); i++) begin
                    if (hit < 0 && held_entries[i].id == id)
                        hit = i;
                end
                if (hit < 0) begin
                    want.status = spq_pkg::STAT_NOT_FOUND;
                end else begin
                    kept_arr = held_entries[hit].arr;
                    held_entries.delete(hit);
                    place_entry(id, sev, kept_arr);
                end
            end
            default: ;  // reserved code leaves the queue alone
        endcase
        want.occupancy = 5'(held_entries.size());
        pending_responses.push_back(want);
    endfunction

    task flag_mismatch(string what);
        mismatch_count++;
        $display("mismatch on result %0d: %s", response_index, what);
    endtask

    // called once per accepted result transaction
    task check_response(logic [39:0] data, logic [1:0] user);
        queue_response_t want;
        if (pending_responses.size() == 0) begin
            flag_mismatch("result with no operation pending");
            response_index++;
            return;
        end
        want = pending_responses.pop_front();
        if (user !== want.status)
            flag_mismatch($sformatf("status %0d, expected %0d", user, want.status));
        if (data[7:0] !== want.popped_id)
            flag_mismatch($sformatf("popped id %0h, expected %0h", data[7:0], want.popped_id));
        if (data[15:8] !== want.popped_sev)
            flag_mismatch($sformatf("popped severity %0h, expected %0h",
                                    data[15:8], want.popped_sev));
        if (data[31:16] !== want.popped_arr)
            flag_mismatch($sformatf("popped arrival %0h, expected %0h",
                                    data[31:16], want.popped_arr));
        if (data[36:32] !== want.occupancy)
            flag_mismatch($sformatf("occupancy %0d, expected %0d",
                                    data[36:32], want.occupancy));
        if (data[39:37] !== 3'b000)
            flag_mismatch($sformatf("padding bits %b not zero", data[39:37]));
        response_index++;
    endtask
endclass

module sorted_priority_queue_update_key_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // the one operation code the block ignores
    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam int         ITEMS_PER_PHASE = 250;
    // long enough to cover any work still in flight
    localparam int         SETTLE_CYCLES = 8 * spq_pkg::DEPTH;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;  // entry_id[7:0], severity[15:8], arrival_time[31:16]
    logic [1:0]  s_axis_tuser  = '0;  // operation[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // popped_id[7:0], popped_severity[15:8],
                                      // popped_arrival[31:16], occupancy[36:32], zero[39:37]
    logic [1:0]  m_axis_tuser;        // status[1:0]

    // idle odds out of a hundred, per side
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    priority_queue_tracker queue_model = new;

    sorted_priority_queue_update_key i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // result side back-pressure, redrawn every cycle
    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // both channels are sampled here with their pre-edge values, so a transaction
    // counts exactly when the block itself sees it
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                queue_model.apply_operation(s_axis_tuser, s_axis_tdata[7:0],
                                            s_axis_tdata[15:8], s_axis_tdata[31:16]);
            if (m_axis_tvalid && m_axis_tready)
                queue_model.check_response(m_axis_tdata, m_axis_tuser);
        end
    end

    // one input transaction, with random idle cycles ahead of it; tvalid stays high
    // between back-to-back transactions
    task automatic drive_op(input logic [1:0] op, input logic [7:0] id,
                            input logic [7:0] sev, input logic [15:0] arr);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {arr, sev, id};
        s_axis_tuser  <= op;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
    endtask

    // stop sending and let every outstanding result come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (queue_model.pending_responses.size() != 0)
            @(posedge aclk);
    endtask

    // a small id pool keeps updates finding their target most of the time
    function automatic logic [7:0] pick_id();
        return ($urandom_range(99) < 75) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
    endfunction

    // bias toward low values so severity and full ties are frequent
    function automatic logic [7:0] pick_sev();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40)
            return 8'($urandom_range(3));
        else if (roll < 50)
            return $urandom_range(1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [15:0] pick_arr();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40)
            return 16'($urandom_range(3));
        else if (roll < 50)
            return $urandom_range(1) ? 16'hFFFF : 16'h0000;
        return 16'($urandom_range(65535));
    endfunction

    // insert-heavy phases push toward a full queue, pop-heavy ones toward empty
    function automatic logic [1:0] pick_op(bit fill_bias);
        int roll;
        roll = $urandom_range(99);
        if (roll < (fill_bias ? 45 : 30))
            return spq_pkg::OP_INSERT;
        else if (roll < 75)
            return spq_pkg::OP_POP;
        else if (roll < 95)
            return spq_pkg::OP_UPDATE;
        return OP_RESERVED;
    endfunction

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty-queue cases: pop, update miss, reserved code
        drive_op(spq_pkg::OP_POP,    8'h00, 8'h00, 16'h0000);
        drive_op(spq_pkg::OP_UPDATE, 8'h10, 8'h20, 16'h0000);
        drive_op(OP_RESERVED,        8'h00, 8'h00, 16'h0000);
        // field extremes and both tie-break rules
        drive_op(spq_pkg::OP_INSERT, 8'h00, 8'h00, 16'h0000);
        drive_op(spq_pkg::OP_INSERT, 8'hFF, 8'hFF, 16'hFFFF);
        drive_op(spq_pkg::OP_INSERT, 8'h5A, 8'hFF, 16'h0000);  // equal severity, earlier arrival
        drive_op(spq_pkg::OP_INSERT, 8'hA5, 8'hFF, 16'hFFFF);  // full tie goes behind
        drive_op(spq_pkg::OP_UPDATE, 8'h77, 8'h01, 16'h0000);  // id not held
        drive_op(spq_pkg::OP_UPDATE, 8'hFF, 8'h00, 16'h1234);  // arrival input must be ignored
        // fill to the top with a repeated id
        for (int i = 0; i < 12; i++)
            drive_op(spq_pkg::OP_INSERT, 8'h33, 8'(i * 21), 16'(i));
        drive_op(spq_pkg::OP_INSERT, 8'hEE, 8'hFF, 16'h0000);  // full, dropped
        drive_op(spq_pkg::OP_UPDATE, 8'h33, 8'h80, 16'h0000);  // first match in priority order
        drive_op(spq_pkg::OP_POP,    8'h00, 8'h00, 16'h0000);
        drive_op(OP_RESERVED,        8'hFF, 8'hFF, 16'hFFFF);
        drain_results();

        // random phases: free running, slow sender, slow receiver, both lightly
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 70; end
                default: begin send_idle_pct = 12; recv_stall_pct <= 12; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                drive_op(pick_op(phase % 2 == 0), pick_id(), pick_sev(), pick_arr());
            // hold off the sender until the queue has answered everything
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (queue_model.mismatch_count == 0 && queue_model.pending_responses.size() == 0)
            $display("sorted_priority_queue_update_key verification clean");
        else
            $display("sorted_priority_queue_update_key verification failed");
        $finish;
    end

    // hang guard, several times the slowest legal run
    initial begin
        #4_000_000;
        $display("sorted_priority_queue_update_key verification failed");
        $finish;
    end

endmodule
